// ===== src/lldpdu_tlv_validator_assert.svh =====
// Assertion helpers for the validator RTL.
`ifndef LLDPDU_TLV_VALIDATOR_ASSERT_SVH
`define LLDPDU_TLV_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LTV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LTV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ltv_pkg.sv =====
`default_nettype none

package ltv_pkg;

    // Frame layout
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFFSET_W        = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MAC_W           = 48;
    localparam logic [15:0] LLDP_ETHERTYPE = 16'h88CC;
    localparam logic [MAC_W-1:0] STATION_MAC_RESET = 48'h018C2000000E;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = MAC_W;
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_STATION_MAC    = 1'b1;

    // TLV constants
    localparam logic [6:0] TLV_TYPE_END  = 7'd0;
    localparam logic [6:0] TLV_TYPE_TTL  = 7'd3;
    localparam logic [6:0] TLV_TYPE_LAST_TRACKED = 7'd8;
    localparam logic [8:0] TTL_LEN       = 9'd2;
    localparam logic [9:0] MANDATORY_TLVS = 10'd3;
    localparam logic [9:0] TLV_COUNT_MAX = 10'd1023;
    localparam int SEEN_W      = 9;
    localparam int SEEN_TTL_BIT = 3;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ORDER    = 3'd1,
        ERR_EXTRA    = 3'd2,
        ERR_TTL_LEN  = 3'd3,
        ERR_OVERRUN  = 3'd4,
        ERR_ZERO_LEN = 3'd5
    } err_code_t;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_BODY = 2'd2
    } tlv_phase_t;

    // Parser status, as it stands after the current beat
    typedef struct packed {
        tlv_phase_t        phase;
        logic [9:0]        count;
        logic [SEEN_W-1:0] seen;
        err_code_t         err;
        logic              end_found;
        logic [15:0]       ttl;
    } tlv_stat_t;

    // Verdict; first field in the highest bits, so members run high to low
    typedef struct packed {
        logic [31:0]       frames_error_total;
        logic [31:0]       frames_in_total;
        logic [SEEN_W-1:0] types_seen;
        logic [10:0]       tlv_count;
        logic [MAC_W-1:0]  source_mac;
        logic [15:0]       ttl_seconds;
        err_code_t         error_code;
        logic              frame_ok;
    } verdict_t;

    localparam int VERDICT_W = $bits(verdict_t);

endpackage

`default_nettype wire

// ===== src/ltv_tlv_parser.sv =====
`default_nettype none

module ltv_tlv_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              parse_en,
    input  wire logic              frame_end,
    input  wire logic [7:0]        data_byte,
    output ltv_pkg::tlv_stat_t     stat_next
);
    import ltv_pkg::*;

    tlv_stat_t   stat_reg;
    tlv_stat_t   stat_n;
    logic [7:0]  header_high_reg, header_high_next;
    logic [6:0]  cur_type_reg, cur_type_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;

    logic [15:0] head;
    logic [8:0]  hlen;
    logic [6:0]  htype;
    logic [9:0]  cnt_inc;
    err_code_t   herr;
    logic        finish;
    logic [6:0]  fin_type;

    assign head    = {header_high_reg, data_byte};
    assign hlen    = head[8:0];
    assign htype   = head[15:9];
    assign cnt_inc = (stat_reg.count != TLV_COUNT_MAX) ? stat_reg.count + 10'd1
                                                       : stat_reg.count;

    // Header checks, in priority order
    always_comb begin
        herr = ERR_NONE;
        if (cnt_inc <= MANDATORY_TLVS) begin
            if (cnt_inc != {3'b000, htype}) herr = ERR_ORDER;
        end else if (htype inside {[7'd1:7'd3]}) begin
            herr = ERR_EXTRA;
        end
        if (herr == ERR_NONE && htype == TLV_TYPE_TTL && hlen != TTL_LEN)
            herr = ERR_TTL_LEN;
        if (herr == ERR_NONE && hlen == 9'd0 && htype != TLV_TYPE_END)
            herr = ERR_ZERO_LEN;
    end

    always_comb begin
        stat_n           = stat_reg;
        header_high_next = header_high_reg;
        cur_type_next    = cur_type_reg;
        bytes_left_next  = bytes_left_reg;
        finish           = 1'b0;
        fin_type         = cur_type_reg;
        if (parse_en && stat_reg.err == ERR_NONE && !stat_reg.end_found) begin
            case (stat_reg.phase)
                PH_HIGH: begin
                    header_high_next = data_byte;
                    stat_n.phase     = PH_LOW;
                end
                PH_LOW: begin
                    stat_n.count = cnt_inc;
                    if (herr != ERR_NONE) begin
                        stat_n.err = herr;
                    end else begin
                        cur_type_next   = htype;
                        bytes_left_next = hlen;
                        if (hlen == 9'd0) begin
                            finish   = 1'b1;
                            fin_type = htype;
                        end else begin
                            stat_n.phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (cur_type_reg == TLV_TYPE_TTL)
                        stat_n.ttl = {stat_reg.ttl[7:0], data_byte};
                    bytes_left_next = bytes_left_reg - 9'd1;
                    if (bytes_left_reg == 9'd1) finish = 1'b1;
                end
                default: stat_n.phase = PH_HIGH;
            endcase
        end
        // Close the TLV: mark its type, note End
        if (finish) begin
            if (fin_type <= TLV_TYPE_LAST_TRACKED) stat_n.seen[fin_type[3:0]] = 1'b1;
            if (fin_type == TLV_TYPE_END) stat_n.end_found = 1'b1;
            stat_n.phase = PH_HIGH;
        end
    end

    assign stat_next = stat_n;

    always_ff @(posedge aclk) begin
        if (!aresetn || frame_end) begin
            stat_reg <= '0;
        end else begin
            stat_reg <= stat_n;
        end
    end

    always_ff @(posedge aclk) begin
        header_high_reg <= header_high_next;
        cur_type_reg    <= cur_type_next;
        bytes_left_reg  <= bytes_left_next;
    end

endmodule

`default_nettype wire

// ===== src/lldpdu_tlv_validator.sv =====
// LLDPDU TLV validator.
// Input stream (s_): one frame byte per beat, destination MAC first, s_tlast on
// the final byte. Bytes 14 and up are parsed as 7-bit type / 9-bit length TLVs.
// Output stream (m_): one verdict beat per accepted frame, i.e. receive enabled,
// destination equal to station_mac, ethertype 0x88CC and at least 14 bytes.
// Other frames leave no trace on m_ and do not move the frame counters.
// Throughput: one byte per clock while s_tready is high; each accepted byte
// updates the header capture and TLV parser registers as it is taken.
// Latency: the verdict is on m_tdata the cycle after the final byte's beat if
// the output register can take it. Stall: a verdict waiting on m_tready stays
// in the output register; a second verdict parks in a one-entry skid buffer,
// and only then does s_tready drop until the output register drains.
// Configuration: cfg_we/cfg_index/cfg_wdata write receive_enable (index 0) or
// station_mac (index 1); write only between frames.
// Reset (aresetn low, synchronous): receive disabled, station_mac back to
// 01-8C-20-00-00-0E, counters and frame state cleared, both output stages empty.
`default_nettype none

module lldpdu_tlv_validator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input bytes
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [7:0]                        s_tdata,   // data_byte[7:0]
    input  wire logic                              s_tlast,   // last_byte
    // verdicts
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [0] frame_ok, [3:1] error_code, [19:4] ttl_seconds, [67:20] source_mac,
    // [78:68] tlv_count, [87:79] types_seen, [119:88] frames_in_total,
    // [151:120] frames_error_total
    output      logic [ltv_pkg::VERDICT_W-1:0]     m_tdata,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [ltv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ltv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ltv_pkg::*;

`include "lldpdu_tlv_validator_assert.svh"

    // Configuration registers
    logic             rx_enable_reg;
    logic [MAC_W-1:0] station_mac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_enable_reg   <= 1'b0;
            station_mac_reg <= STATION_MAC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RECEIVE_ENABLE: rx_enable_reg   <= cfg_wdata[0];
                REG_STATION_MAC:    station_mac_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame header capture
    logic                in_beat;
    logic [OFFSET_W-1:0] byte_offset_reg, byte_offset_next;
    logic [MAC_W-1:0]    dest_reg, src_reg;
    logic [15:0]         etype_reg;
    logic                drop_reg, drop_eff;
    logic                at_etype_end;
    logic                parse_en;

    assign in_beat          = s_tvalid && s_tready;
    assign byte_offset_next = (byte_offset_reg < OFFSET_W'(MAX_FRAME_BYTES))
                            ? byte_offset_reg + OFFSET_W'(1) : byte_offset_reg;
    assign at_etype_end     = (byte_offset_reg == OFFSET_W'(13));
    // Decide drop on the last ethertype byte, with that byte folded in
    assign drop_eff = at_etype_end
                    ? (({etype_reg[7:0], s_tdata} != LLDP_ETHERTYPE) ||
                       (dest_reg != station_mac_reg))
                    : drop_reg;
    assign parse_en = in_beat && (byte_offset_reg >= OFFSET_W'(14)) &&
                      (byte_offset_reg < OFFSET_W'(MAX_FRAME_BYTES)) && !drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= '0;
            drop_reg        <= 1'b0;
        end else if (in_beat) begin
            if (s_tlast) begin
                byte_offset_reg <= '0;
                drop_reg        <= 1'b0;
            end else begin
                byte_offset_reg <= byte_offset_next;
                drop_reg        <= drop_eff;
            end
        end
    end

    // Shift in address and ethertype bytes; stale values are overwritten next frame
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            if (byte_offset_reg < OFFSET_W'(6))
                dest_reg <= {dest_reg[MAC_W-9:0], s_tdata};
            else if (byte_offset_reg < OFFSET_W'(12))
                src_reg <= {src_reg[MAC_W-9:0], s_tdata};
            else if (byte_offset_reg < OFFSET_W'(14))
                etype_reg <= {etype_reg[7:0], s_tdata};
        end
    end

    // TLV parser
    tlv_stat_t stat_next;

    ltv_tlv_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .parse_en  (parse_en),
        .frame_end (in_beat && s_tlast),
        .data_byte (s_tdata),
        .stat_next (stat_next)
    );

    // Verdict
    logic        res_valid;
    err_code_t   res_err;
    logic [10:0] res_cnt;
    logic [31:0] frames_in_reg, frames_err_reg;
    logic [31:0] frames_in_next, frames_err_next;
    verdict_t    res_data;

    assign res_valid = in_beat && s_tlast && rx_enable_reg && !drop_eff &&
                       (byte_offset_next >= OFFSET_W'(14));

    always_comb begin
        res_err = stat_next.err;
        res_cnt = {1'b0, stat_next.count};
        // No End TLV and no earlier error: overrun; count the attempted TLV
        if (stat_next.err == ERR_NONE && !stat_next.end_found) begin
            res_err = ERR_OVERRUN;
            if (stat_next.phase != PH_BODY) res_cnt = res_cnt + 11'd1;
        end
    end

    assign frames_in_next  = frames_in_reg + 32'd1;
    assign frames_err_next = frames_err_reg + {31'd0, (res_err != ERR_NONE)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_reg  <= '0;
            frames_err_reg <= '0;
        end else if (res_valid) begin
            frames_in_reg  <= frames_in_next;
            frames_err_reg <= frames_err_next;
        end
    end

    always_comb begin
        res_data.frame_ok           = (res_err == ERR_NONE);
        res_data.error_code         = res_err;
        res_data.ttl_seconds        = stat_next.seen[SEEN_TTL_BIT] ? stat_next.ttl : 16'd0;
        res_data.source_mac         = src_reg;
        res_data.tlv_count          = res_cnt;
        res_data.types_seen         = stat_next.seen;
        res_data.frames_in_total    = frames_in_next;
        res_data.frames_error_total = frames_err_next;
    end

    // Output register plus one-entry skid
    logic     out_valid_reg, skid_valid_reg;
    verdict_t out_data_reg, skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            // Output free: drain the skid first, else take the new verdict
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (res_valid) begin
            skid_data_reg <= res_data;
        end
    end

    `LTV_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds a verdict while the output register is empty")
    `LTV_ASSERT_NOW(a_ok_matches_code, aclk, aresetn, out_valid_reg, out_data_reg.frame_ok == (out_data_reg.error_code == ERR_NONE), "frame_ok disagrees with error_code")
    `LTV_ASSERT_NEXT(a_offset_clears, aclk, aresetn, in_beat && s_tlast, byte_offset_reg == '0, "byte offset not cleared after the final byte")

endmodule

`default_nettype wire

// ===== tb/sv/lldpdu_verdict_checker.sv =====
`default_nettype none

module lldpdu_verdict_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [7:0]                     s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [ltv_pkg::VERDICT_W-1:0]   m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [ltv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ltv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ltv_pkg::*;

    localparam int ETH_HDR_BYTES = 14;

    // mirrored configuration
    logic              rx_enable;
    logic [MAC_W-1:0]  station_addr;

    // frame parse state
    logic [OFFSET_W-1:0] offset;
    tlv_phase_t          phase;
    logic [7:0]          hdr_hi;
    logic [6:0]          cur_type;
    logic [8:0]          remaining;
    logic [9:0]          tlv_cnt;
    logic [SEEN_W-1:0]   seen;
    err_code_t           err_latch;
    logic                end_seen;
    logic                foreign;
    logic [15:0]         ttl;
    logic [MAC_W-1:0]    dst;
    logic [MAC_W-1:0]    src;
    logic [15:0]         etype;
    logic [31:0]         rx_frames;
    logic [31:0]         rx_errors;

    verdict_t expected_verdicts[$];

    task automatic clear_frame();
        offset    = '0;
        phase     = PH_HIGH;
        hdr_hi    = '0;
        cur_type  = '0;
        remaining = '0;
        tlv_cnt   = '0;
        seen      = '0;
        err_latch = ERR_NONE;
        end_seen  = 1'b0;
        foreign   = 1'b0;
        ttl       = '0;
        dst       = '0;
        src       = '0;
        etype     = '0;
    endtask

    task automatic close_tlv();
        if (cur_type <= TLV_TYPE_LAST_TRACKED)
            seen[cur_type[3:0]] = 1'b1;
        if (cur_type == TLV_TYPE_END)
            end_seen = 1'b1;
        phase = PH_HIGH;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [OFFSET_W-1:0] off;
        logic [6:0]          kind;
        logic [8:0]          len;
        err_code_t           e;
        logic [10:0]         cnt;
        verdict_t            v;
        off = offset;
        if (off < 6) begin
            dst = {dst[39:0], b};
        end else if (off < 12) begin
            src = {src[39:0], b};
        end else if (off < ETH_HDR_BYTES) begin
            etype = {etype[7:0], b};
        end else if (off < MAX_FRAME_BYTES && !foreign && err_latch == ERR_NONE && !end_seen) begin
            case (phase)
                PH_HIGH: begin
                    hdr_hi = b;
                    phase  = PH_LOW;
                end
                PH_LOW: begin
                    kind = hdr_hi[7:1];
                    len  = {hdr_hi[0], b};
                    e    = ERR_NONE;
                    if (tlv_cnt != TLV_COUNT_MAX)
                        tlv_cnt++;
                    if (tlv_cnt <= MANDATORY_TLVS) begin
                        if (tlv_cnt != 10'(kind))
                            e = ERR_ORDER;
                    end else if (kind != TLV_TYPE_END && kind <= TLV_TYPE_TTL) begin
                        e = ERR_EXTRA;
                    end
                    if (e == ERR_NONE && kind == TLV_TYPE_TTL && len != TTL_LEN)
                        e = ERR_TTL_LEN;
                    if (e == ERR_NONE && len == '0 && kind != TLV_TYPE_END)
                        e = ERR_ZERO_LEN;
                    if (e != ERR_NONE) begin
                        err_latch = e;
                    end else begin
                        cur_type  = kind;
                        remaining = len;
                        if (len == '0)
                            close_tlv();
                        else
                            phase = PH_BODY;
                    end
                end
                default: begin
                    if (cur_type == TLV_TYPE_TTL)
                        ttl = {ttl[7:0], b};
                    remaining--;
                    if (remaining == '0)
                        close_tlv();
                end
            endcase
        end
        if (off == ETH_HDR_BYTES - 1)
            foreign = (etype != LLDP_ETHERTYPE) || (dst != station_addr);
        if (offset < MAX_FRAME_BYTES)
            offset++;
        if (fin) begin
            if (offset >= ETH_HDR_BYTES && !foreign && rx_enable) begin
                e   = err_latch;
                cnt = {1'b0, tlv_cnt};
                if (e == ERR_NONE && !end_seen) begin
                    e = ERR_OVERRUN;
                    // a frame cut before or inside a header still counts that TLV
                    if (phase != PH_BODY)
                        cnt++;
                end
                rx_frames++;
                if (e != ERR_NONE)
                    rx_errors++;
                v.frame_ok           = (e == ERR_NONE);
                v.error_code         = e;
                v.ttl_seconds        = seen[SEEN_TTL_BIT] ? ttl : 16'd0;
                v.source_mac         = src;
                v.tlv_count          = cnt;
                v.types_seen         = seen;
                v.frames_in_total    = rx_frames;
                v.frames_error_total = rx_errors;
                expected_verdicts.push_back(v);
            end
            clear_frame();
        end
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (!aresetn) begin
            rx_enable    = 1'b0;
            station_addr = STATION_MAC_RESET;
            rx_frames    = '0;
            rx_errors    = '0;
            clear_frame();
            expected_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            // compare first: a verdict leaving now belongs to an earlier frame
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_verdicts.size() == 0) begin
                    $error("verdict beat with no frame pending: 0x%0h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("frame_ok", 64'(want.frame_ok), 64'(got.frame_ok));
                    check_field("error_code", 64'(want.error_code), 64'(got.error_code));
                    check_field("ttl_seconds", 64'(want.ttl_seconds), 64'(got.ttl_seconds));
                    check_field("source_mac", 64'(want.source_mac), 64'(got.source_mac));
                    check_field("tlv_count", 64'(want.tlv_count), 64'(got.tlv_count));
                    check_field("types_seen", 64'(want.types_seen), 64'(got.types_seen));
                    check_field("frames_in_total", 64'(want.frames_in_total),
                                64'(got.frames_in_total));
                    check_field("frames_error_total", 64'(want.frames_error_total),
                                64'(got.frames_error_total));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_RECEIVE_ENABLE: rx_enable    = cfg_wdata[0];
                    REG_STATION_MAC:    station_addr = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            outstanding = expected_verdicts.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/lldpdu_tlv_validator_test.sv =====
`default_nettype none

module lldpdu_tlv_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ltv_pkg::*;

    localparam logic [6:0]       TLV_CHASSIS_ID = 7'd1;
    localparam logic [6:0]       TLV_PORT_ID    = 7'd2;
    localparam logic [MAC_W-1:0] MAC_ALL_ONES   = '1;
    localparam int               LONG_HOLD      = 600;
    localparam int               RANDOM_BYTES   = 1000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [7:0]             s_tdata   = '0;   // data_byte[7:0]
    logic                   s_tlast   = 1'b0; // last_byte
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    wire logic                 s_tready;
    wire logic                 m_tvalid;
    wire logic [VERDICT_W-1:0] m_tdata;
    int mismatches;
    int outstanding;

    // frame under construction, destination MAC first
    logic [7:0]       frame_buf[$];
    logic [MAC_W-1:0] station_addr = STATION_MAC_RESET;
    bit               tx_idle;
    bit               rx_idle;
    bit               hold_req;
    int               bytes_sent;

    always #4 aclk = ~aclk;

    lldpdu_tlv_validator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lldpdu_verdict_checker verdict_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Start a new frame: destination, source, ethertype, all big endian.
    task automatic put_head(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                            input logic [15:0] etype);
        frame_buf.delete();
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(dst[8*i +: 8]);
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(src[8*i +: 8]);
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
    endtask

    // Append a TLV header and a body of random bytes.
    task automatic put_tlv(input logic [6:0] kind, input logic [8:0] len);
        frame_buf.push_back({kind, len[8]});
        frame_buf.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
    endtask

    task automatic put_ttl(input logic [15:0] secs);
        put_tlv(TLV_TYPE_TTL, TTL_LEN);
        frame_buf[$-1] = secs[15:8];
        frame_buf[$]   = secs[7:0];
    endtask

    // Chassis ID, Port ID and TTL in the required order.
    task automatic put_mandatory();
        put_tlv(TLV_CHASSIS_ID, 9'($urandom_range(1, 12)));
        put_tlv(TLV_PORT_ID, 9'($urandom_range(1, 12)));
        put_tlv(TLV_TYPE_TTL, TTL_LEN);
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offer one beat and hold it until accepted. With tx_idle set, a random gap
    // goes in front of some beats, so idle cycles land inside and between frames.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (tx_idle && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        bytes_sent += frame_buf.size();
    endtask

    // Stop offering beats and wait until every expected verdict has left.
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both registers back to back; call only while drained.
    task automatic program_regs(input logic enable, input logic [MAC_W-1:0] mac);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RECEIVE_ENABLE;
        cfg_wdata <= CFG_DATA_W'(enable);
        @(posedge aclk);
        cfg_index <= REG_STATION_MAC;
        cfg_wdata <= mac;
        @(posedge aclk);
        cfg_we <= 1'b0;
        station_addr = mac;
    endtask

    // Mostly well-formed LLDPDUs with random content; about four in ten
    // frames carry one defect.
    task automatic random_frame();
        int               mode;
        int               n;
        logic [MAC_W-1:0] dst;
        logic [15:0]      etype;
        mode  = $urandom_range(0, 27);
        dst   = (mode == 0) ? random_mac() : station_addr;
        etype = (mode == 1) ? 16'($urandom) : LLDP_ETHERTYPE;
        put_head(dst, random_mac(), etype);
        case (mode)
            2: begin
                // runt frame, cut inside the Ethernet header
                n = $urandom_range(1, 13);
                while (frame_buf.size() > n)
                    void'(frame_buf.pop_back());
            end
            3: begin
                put_tlv(7'($urandom_range(0, 127)), 9'($urandom_range(0, 8)));
                put_mandatory();
            end
            4: begin
                put_tlv(TLV_CHASSIS_ID, 9'($urandom_range(1, 12)));
                put_tlv(TLV_PORT_ID, 9'($urandom_range(1, 12)));
                put_tlv(TLV_TYPE_TTL, 9'($urandom_range(0, 6)));
            end
            default: put_mandatory();
        endcase
        if (mode != 2) begin
            repeat ($urandom_range(0, 4))
                put_tlv(7'($urandom_range(4, 127)), 9'($urandom_range(1, 12)));
            if (mode == 5)
                put_tlv(7'($urandom_range(4, 127)), 9'd0);
            if (mode == 6)
                put_tlv(7'($urandom_range(1, 3)), 9'($urandom_range(1, 6)));
            if (mode == 10)
                put_tlv(TLV_TYPE_END, 9'($urandom_range(1, 6)));
            else if (mode != 7)
                put_tlv(TLV_TYPE_END, 9'd0);
            if (mode == 9)
                repeat ($urandom_range(1, 8))
                    frame_buf.push_back(8'($urandom));
            if (mode == 8) begin
                n = $urandom_range(14, frame_buf.size() - 1);
                while (frame_buf.size() > n)
                    void'(frame_buf.pop_back());
            end
        end
        send_frame();
    endtask

    // Verdict side: short random stalls, plus one long hold-off on request.
    initial begin
        wait (aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (hold_req) begin
                // hold long enough for both output stages to fill and stall s_
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [MAC_W-1:0] mac;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // receive is off out of reset: a clean LLDPDU must vanish
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();
        drain();
        program_regs(1'b1, STATION_MAC_RESET);

        // clean frames, TTL and source MAC at both ends
        put_head(station_addr, MAC_ALL_ONES, LLDP_ETHERTYPE);
        put_tlv(TLV_CHASSIS_ID, 9'd7);
        put_tlv(TLV_PORT_ID, 9'd5);
        put_ttl(16'hFFFF);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();
        put_head(station_addr, '0, LLDP_ETHERTYPE);
        put_tlv(TLV_CHASSIS_ID, 9'd1);
        put_tlv(TLV_PORT_ID, 9'd1);
        put_ttl(16'h0000);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // Port ID first, then more TLVs that must be ignored after the error
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_tlv(TLV_PORT_ID, 9'd4);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // End TLV in place of the Chassis ID
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // a second Chassis ID after the mandatory set
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(TLV_CHASSIS_ID, 9'd3);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // TTL with a three-byte body
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_tlv(TLV_CHASSIS_ID, 9'd2);
        put_tlv(TLV_PORT_ID, 9'd2);
        put_tlv(TLV_TYPE_TTL, 9'd3);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // zero length on an optional TLV, then on the Chassis ID
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(7'd4, 9'd0);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_tlv(TLV_CHASSIS_ID, 9'd0);
        send_frame();

        // missing End: frame stops at a TLV boundary, then inside a header
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        send_frame();
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        frame_buf.push_back(8'h00);
        send_frame();

        // frame stops inside a TLV body
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(7'd5, 9'd20);
        repeat (5) void'(frame_buf.pop_back());
        send_frame();

        // junk after End must be ignored
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd0);
        put_tlv(TLV_CHASSIS_ID, 9'd0);
        repeat (6) frame_buf.push_back(8'($urandom));
        send_frame();

        // End TLV that carries a body
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd3);
        send_frame();

        // every tracked optional type plus unknown types at both ends
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        for (int k = 4; k <= 8; k++)
            put_tlv(7'(k), 9'd4);
        put_tlv(7'd9, 9'd1);
        put_tlv(7'd127, 9'd1);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // overlong frame: longest bodies, End lies past the parse limit
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        repeat (4) put_tlv(7'd127, 9'h1FF);
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();

        // header only, one byte short of it, and a single byte
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        send_frame();
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
        void'(frame_buf.pop_back());
        send_frame();
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        send_frame();

        // foreign frames: wrong ethertype, wrong destination
        put_head(station_addr, random_mac(), LLDP_ETHERTYPE ^ 16'h0001);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();
        put_head(station_addr ^ 48'h1, random_mac(), LLDP_ETHERTYPE);
        put_mandatory();
        put_tlv(TLV_TYPE_END, 9'd0);
        send_frame();
        drain();

        // back-pressure: keep offering short frames while the verdict side holds
        hold_req = 1'b1;
        repeat (6) begin
            put_head(station_addr, random_mac(), LLDP_ETHERTYPE);
            put_mandatory();
            put_tlv(TLV_TYPE_END, 9'd0);
            send_frame();
        end
        drain();

        // random phases, each under its own register setting; the last one
        // runs with no idling on either side
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: mac = STATION_MAC_RESET;
                1: mac = '0;
                2: mac = random_mac();
                3: mac = STATION_MAC_RESET;
                default: mac = MAC_ALL_ONES;
            endcase
            drain();
            program_regs(p != 3, mac);
            if (p == 4) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            bytes_sent = 0;
            while (bytes_sent < ((p == 3) ? RANDOM_BYTES / 18 : RANDOM_BYTES / 4))
                random_frame();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
